FILE: rtl/scc_pkg.sv
package scc_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int NODE_W        = 6;
    localparam int COUNT_W       = 7;
    localparam int ROW_W         = 64;

    typedef struct packed {
        logic [NODE_W-1:0] row_index;
        logic [ROW_W-1:0]  row_bits;
        logic              last_row;
    } scc_in_t;

    typedef struct packed {
        logic              graph_cyclic;
        logic [NODE_W-1:0] node_id;
        logic [NODE_W-1:0] component_index;
        logic              component_end;
        logic              run_end;
    } scc_out_t;

endpackage

FILE: rtl/scc_if.sv
interface scc_in_if;
    logic              valid;
    logic              ready;
    scc_pkg::scc_in_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface scc_out_if;
    logic              valid;
    logic              ready;
    scc_pkg::scc_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface scc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [scc_pkg::COUNT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/scc_or_topological_sort.sv
// channel    | dir | payload                                        | accept
// in_ch      | in  | row_index, row_bits, last_row                  | valid & ready
// out_ch     | out | graph_cyclic, node_id, component_index,        | valid & ready
//            |     | component_end, run_end                         |
// cfg_ch     | in  | data = node_count (7 bits)                     | valid & ready
//
// A non-last row is only stored. On a last row the first DFS checks each root, pushes
// and pops nodes on the walk stack and looks for a cycle. Acyclic: nodes are emitted
// in reverse finish order. Cyclic: the transposed walk scans a column each time a node
// becomes top of stack, after a push as well as after a pop in the SCC pass.
// Results leave through one output register; the walk stalls in any emitting state
// while it is full. Reset is asynchronous and clears control state only.
module scc_or_topological_sort
#(
    parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    scc_in_if.sink    in_ch,
    scc_out_if.source out_ch,
    scc_cfg_if.sink   cfg_ch
);
    import scc_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef enum logic [3:0] {
        S_LOAD, S_ROOT, S_RD, S_ROW, S_STEP, S_POP, S_TOP, S_OREAD, S_OUT,
        S_SREAD, S_SROOT, S_COL, S_SSTEP, S_SPOP, S_STOP, S_FLUSH
    } state_t;

    // adjacency rows, walk stack, finish order
    logic [ROW_W-1:0]  adj_mem [MAX_NODES];
    logic [NODE_W-1:0] stk_mem [MAX_NODES];
    logic [NODE_W-1:0] fin_mem [MAX_NODES];

    state_t             state_reg;
    logic [COUNT_W-1:0] node_count_reg;
    logic [ROW_W-1:0]   visited_reg, grey_reg, cand_reg;
    logic [COUNT_W-1:0] root_reg, depth_reg, fin_reg, scan_reg;
    logic [NODE_W-1:0]  v_reg, comp_reg;
    logic               cyc_reg, hold_valid_reg;
    logic               ovalid_reg;
    scc_out_t           obuf_reg, hold_reg;
    logic [ROW_W-1:0]   adj_rd_reg;
    logic [NODE_W-1:0]  stk_rd_reg, fin_rd_reg;
    logic [AW-1:0]      adj_addr, stk_addr, fin_addr, stk_waddr;
    logic [NODE_W-1:0]  stk_wdata;
    logic               stk_we;

    logic [COUNT_W-1:0] n_eff;
    logic [ROW_W-1:0]   nmask;
    logic [NODE_W-1:0]  lowbit;
    logic               in_fire;
    logic               can_emit, sroot_go, emit;
    scc_out_t           emit_data;

    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = COUNT_W'(1);
        else if (node_count_reg > COUNT_W'(MAX_NODES))
            n_eff = COUNT_W'(MAX_NODES);
        else
            n_eff = node_count_reg;
        for (int i = 0; i < ROW_W; i++)
            nmask[i] = (COUNT_W'(i) < n_eff);
        lowbit = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
            if (cand_reg[i])
                lowbit = NODE_W'(i);
    end

    assign in_ch.ready    = (state_reg == S_LOAD);
    assign in_fire        = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready   = (state_reg == S_LOAD);
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.payload = obuf_reg;

    // result staging: the last SCC node is held until its component and run ends are known
    always_comb
    begin
        can_emit  = !ovalid_reg || out_ch.ready;
        sroot_go  = (root_reg != '0) && !visited_reg[fin_rd_reg] &&
                    (!hold_valid_reg || can_emit);
        emit      = 1'b0;
        emit_data = hold_reg;
        if (state_reg == S_OUT)
        begin
            emit                      = can_emit;
            emit_data.graph_cyclic    = 1'b0;
            emit_data.node_id         = fin_rd_reg;
            emit_data.component_index = NODE_W'(n_eff - fin_reg);
            emit_data.component_end   = 1'b1;
            emit_data.run_end         = (fin_reg == COUNT_W'(1));
        end
        else if (state_reg == S_SROOT)
            emit = sroot_go && hold_valid_reg;
        else if (state_reg == S_SSTEP)
            emit = (cand_reg != '0) && can_emit;
        else if (state_reg == S_FLUSH)
        begin
            emit              = can_emit;
            emit_data.run_end = 1'b1;
        end
    end

    // memory addresses are chosen by state; read data is registered and lands in the next cycle
    always_comb
    begin
        adj_addr = (state_reg == S_COL) ? AW'(scan_reg) : AW'(v_reg);
        stk_addr = AW'(depth_reg - COUNT_W'(1));
        if (state_reg == S_OREAD || state_reg == S_OUT)
            fin_addr = AW'(fin_reg - COUNT_W'(1));
        else
            fin_addr = AW'(root_reg - COUNT_W'(1));
        stk_we    = 1'b0;
        stk_waddr = AW'(depth_reg);
        stk_wdata = lowbit;
        if (state_reg == S_ROOT && root_reg != n_eff &&
            !visited_reg[root_reg[NODE_W-1:0]])
        begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = root_reg[NODE_W-1:0];
        end
        else if (state_reg == S_SROOT && sroot_go)
        begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = fin_rd_reg;
        end
        else if ((state_reg == S_STEP && cand_reg != '0) ||
                 (state_reg == S_SSTEP && emit))
            stk_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && ({1'b0, in_ch.payload.row_index} < COUNT_W'(MAX_NODES)))
            adj_mem[AW'(in_ch.payload.row_index)] <= in_ch.payload.row_bits;
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (state_reg == S_STEP && cand_reg == '0)
            fin_mem[AW'(fin_reg)] <= v_reg;
        adj_rd_reg <= adj_mem[adj_addr];
        stk_rd_reg <= stk_mem[stk_addr];
        fin_rd_reg <= fin_mem[fin_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            node_count_reg <= COUNT_W'(64);
            ovalid_reg     <= 1'b0;
            visited_reg    <= '0;
            grey_reg       <= '0;
            cand_reg       <= '0;
            root_reg       <= '0;
            depth_reg      <= '0;
            fin_reg        <= '0;
            scan_reg       <= '0;
            v_reg          <= '0;
            comp_reg       <= '0;
            cyc_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
            obuf_reg       <= '0;
        end
        else
        begin
            if (emit)
            begin
                ovalid_reg <= 1'b1;
                obuf_reg   <= emit_data;
            end
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (cfg_ch.valid)
                        node_count_reg <= cfg_ch.data;
                    if (in_fire && in_ch.payload.last_row)
                    begin
                        visited_reg <= '0;
                        grey_reg    <= '0;
                        root_reg    <= '0;
                        fin_reg     <= '0;
                        cyc_reg     <= 1'b0;
                        state_reg   <= S_ROOT;
                    end
                end
                // first DFS: next unvisited root
                S_ROOT:
                begin
                    if (root_reg == n_eff)
                    begin
                        if (cyc_reg)
                        begin
                            visited_reg    <= '0;
                            root_reg       <= n_eff;
                            comp_reg       <= '0;
                            hold_valid_reg <= 1'b0;
                            state_reg      <= S_SREAD;
                        end
                        else
                        begin
                            state_reg <= S_OREAD;
                        end
                    end
                    else if (visited_reg[root_reg[NODE_W-1:0]])
                        root_reg <= root_reg + COUNT_W'(1);
                    else
                    begin
                        v_reg       <= root_reg[NODE_W-1:0];
                        visited_reg[root_reg[NODE_W-1:0]] <= 1'b1;
                        grey_reg[root_reg[NODE_W-1:0]]    <= 1'b1;
                        depth_reg   <= COUNT_W'(1);
                        state_reg   <= S_RD;
                    end
                end
                // row of v_reg in flight
                S_RD:
                    state_reg <= S_ROW;
                // back edge to a grey node means a cycle (self-loop included)
                S_ROW:
                begin
                    if ((adj_rd_reg & nmask & grey_reg) != '0)
                        cyc_reg <= 1'b1;
                    cand_reg  <= adj_rd_reg & nmask & ~visited_reg;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (cand_reg != '0)
                    begin
                        visited_reg[lowbit] <= 1'b1;
                        grey_reg[lowbit]    <= 1'b1;
                        v_reg     <= lowbit;
                        depth_reg <= depth_reg + COUNT_W'(1);
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        grey_reg[v_reg] <= 1'b0;
                        fin_reg   <= fin_reg + COUNT_W'(1);
                        depth_reg <= depth_reg - COUNT_W'(1);
                        state_reg <= (depth_reg == COUNT_W'(1)) ? S_ROOT : S_POP;
                    end
                end
                // stack read in flight
                S_POP:
                    state_reg <= S_TOP;
                S_TOP:
                begin
                    v_reg     <= stk_rd_reg;
                    state_reg <= S_RD;
                end
                // acyclic: reverse finish order
                S_OREAD:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (can_emit)
                    begin
                        fin_reg   <= fin_reg - COUNT_W'(1);
                        state_reg <= (fin_reg == COUNT_W'(1)) ? S_LOAD : S_OREAD;
                    end
                end
                // second DFS over transposed matrix, decreasing finish time
                S_SREAD:
                    state_reg <= S_SROOT;
                S_SROOT:
                begin
                    if (root_reg == '0)
                        state_reg <= S_FLUSH;
                    else if (visited_reg[fin_rd_reg])
                    begin
                        root_reg  <= root_reg - COUNT_W'(1);
                        state_reg <= S_SREAD;
                    end
                    else if (sroot_go)
                    begin
                        hold_reg.graph_cyclic    <= 1'b1;
                        hold_reg.node_id         <= fin_rd_reg;
                        hold_reg.component_index <= comp_reg;
                        hold_reg.component_end   <= 1'b0;
                        hold_reg.run_end         <= 1'b0;
                        hold_valid_reg           <= 1'b1;
                        visited_reg[fin_rd_reg]  <= 1'b1;
                        v_reg     <= fin_rd_reg;
                        depth_reg <= COUNT_W'(1);
                        scan_reg  <= '0;
                        cand_reg  <= '0;
                        state_reg <= S_COL;
                    end
                end
                // column of v_reg: one row per cycle, read data trails the address through the read register
                S_COL:
                begin
                    if (scan_reg != '0)
                        cand_reg[NODE_W'(scan_reg - COUNT_W'(1))] <= adj_rd_reg[v_reg] &
                            ~visited_reg[NODE_W'(scan_reg - COUNT_W'(1))];
                    if (scan_reg == n_eff)
                        state_reg <= S_SSTEP;
                    else
                        scan_reg <= scan_reg + COUNT_W'(1);
                end
                S_SSTEP:
                begin
                    if (cand_reg != '0)
                    begin
                        if (can_emit)
                        begin
                            hold_reg.node_id    <= lowbit;
                            visited_reg[lowbit] <= 1'b1;
                            v_reg     <= lowbit;
                            depth_reg <= depth_reg + COUNT_W'(1);
                            scan_reg  <= '0;
                            cand_reg  <= '0;
                            state_reg <= S_COL;
                        end
                    end
                    else
                    begin
                        depth_reg <= depth_reg - COUNT_W'(1);
                        if (depth_reg == COUNT_W'(1))
                        begin
                            hold_reg.component_end <= 1'b1;
                            comp_reg  <= comp_reg + NODE_W'(1);
                            root_reg  <= root_reg - COUNT_W'(1);
                            state_reg <= S_SREAD;
                        end
                        else
                            state_reg <= S_SPOP;
                    end
                end
                S_SPOP:
                    state_reg <= S_STOP;
                S_STOP:
                begin
                    v_reg     <= stk_rd_reg;
                    scan_reg  <= '0;
                    cand_reg  <= '0;
                    state_reg <= S_COL;
                end
                // last held node carries run_end
                S_FLUSH:
                begin
                    if (can_emit)
                    begin
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_LOAD;
                    end
                end
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ch.ready |=> ovalid_reg && $stable(obuf_reg))
        else $error("output transaction changed while stalled");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= COUNT_W'(MAX_NODES))
        else $error("walk stack overflow");

    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_LOAD |-> fin_reg <= n_eff)
        else $error("finish count beyond node count");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SSTEP || state_reg == S_FLUSH) |-> hold_valid_reg)
        else $error("no held result in component walk");
endmodule

FILE: sim/scc_or_topological_sort_tb.sv
`timescale 1ns / 1ps
module scc_or_topological_sort_tb;
    import scc_pkg::*;

    // Settle time before a node_count write. A non-last row produces nothing,
    // so the block may still be draining when the expectation store runs dry.
    localparam int QUIET_CYCLES = 24;

    typedef struct {
        bit        is_cfg;
        bit [6:0]  cfg_val;
        scc_in_t   row;
    } stim_t;

    logic clk;
    logic rst_n;

    scc_in_if  in_ch ();
    scc_out_if out_ch ();
    scc_cfg_if cfg_ch ();

    scc_or_topological_sort u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Predictor state: our own copy of the stored rows and the node count.
    bit [63:0] graph_rows [64];
    bit [6:0]  node_count_q;
    scc_out_t  results_due [$];   // expected output transactions, oldest first
    stim_t     pending [$];       // transactions waiting to be driven
    int        errors;
    int        quiet;             // cycles with nothing outstanding
    int        send_gap;
    int        stall_left;
    bit        in_fire;
    bit        cfg_fire;
    int        rows_sent;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        out_ch.ready   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Node count clamp: 0 acts as 1, above 64 acts as 64.
    function automatic int used_nodes();
        if (node_count_q == 0)
            return 1;
        if (node_count_q > 64)
            return 64;
        return int'(node_count_q);
    endfunction

    // Successors of v (or predecessors when walking the transposed graph),
    // restricted to the nodes in use.
    function automatic bit [63:0] adj_of(int v, int n, bit transposed);
        bit [63:0] m;
        m = '0;
        if (!transposed)
        begin
            for (int j = 0; j < n; j++)
                m[j] = graph_rows[v][j];
        end
        else
        begin
            for (int i = 0; i < n; i++)
                m[i] = graph_rows[i][v];
        end
        return m;
    endfunction

    function automatic int lowest(bit [63:0] m);
        for (int i = 0; i < 64; i++)
            if (m[i])
                return i;
        return 63;
    endfunction

    // Full analysis on a last row: cycle check plus finish ranking, then
    // either topological order or strongly connected components.
    function automatic void predict_run();
        int        n, depth, fin, k, comp, v, w, root;
        int        stack [64];
        int        order [64];
        bit [63:0] seen, grey, cand;
        bit        cyc;
        scc_out_t  r;
        scc_out_t  run_q [$];
        n    = used_nodes();
        seen = '0;
        grey = '0;
        fin  = 0;
        cyc  = 1'b0;
        for (root = 0; root < n; root++)
        begin
            if (seen[root])
                continue;
            depth = 0;
            stack[depth++] = root;
            seen[root] = 1'b1;
            grey[root] = 1'b1;
            if ((adj_of(root, n, 1'b0) & grey) != 0)
                cyc = 1'b1;
            while (depth > 0)
            begin
                v    = stack[depth - 1];
                cand = adj_of(v, n, 1'b0) & ~seen;
                if (cand != 0)
                begin
                    w = lowest(cand);
                    seen[w] = 1'b1;
                    grey[w] = 1'b1;
                    if ((adj_of(w, n, 1'b0) & grey) != 0)
                        cyc = 1'b1;
                    stack[depth++] = w;
                end
                else
                begin
                    grey[v] = 1'b0;
                    depth--;
                    order[fin++] = v;
                end
            end
        end
        if (!cyc)
        begin
            // reverse finish order is a topological order
            for (int idx = 0; idx < n; idx++)
            begin
                r.graph_cyclic    = 1'b0;
                r.node_id         = NODE_W'(order[n - 1 - idx]);
                r.component_index = NODE_W'(idx);
                r.component_end   = 1'b1;
                r.run_end         = (idx == n - 1);
                results_due.insert(results_due.size(), r);
            end
            return;
        end
        // Second pass over the transposed graph, by decreasing finish time.
        seen = '0;
        comp = 0;
        for (int idx = n; idx > 0; idx--)
        begin
            root = order[idx - 1];
            if (seen[root])
                continue;
            depth = 0;
            stack[depth++] = root;
            seen[root] = 1'b1;
            r.graph_cyclic    = 1'b1;
            r.component_end   = 1'b0;
            r.run_end         = 1'b0;
            r.component_index = NODE_W'(comp);
            r.node_id         = NODE_W'(root);
            run_q.insert(run_q.size(), r);
            while (depth > 0)
            begin
                v    = stack[depth - 1];
                cand = adj_of(v, n, 1'b1) & ~seen;
                if (cand != 0)
                begin
                    w = lowest(cand);
                    seen[w] = 1'b1;
                    stack[depth++] = w;
                    r.node_id = NODE_W'(w);
                    run_q.insert(run_q.size(), r);
                end
                else
                    depth--;
            end
            run_q[run_q.size() - 1].component_end = 1'b1;
            comp++;
        end
        run_q[run_q.size() - 1].run_end = 1'b1;
        foreach (run_q[i])
            results_due.insert(results_due.size(), run_q[i]);
    endfunction

    // --- stimulus building ---------------------------------------------------

    localparam int G_DAG    = 0;
    localparam int G_RANDOM = 1;
    localparam int G_EMPTY  = 2;
    localparam int G_FULL   = 3;
    localparam int G_SELF   = 4;
    localparam int G_RING   = 5;

    function automatic void queue_cfg(bit [6:0] value);
        stim_t s;
        s.is_cfg  = 1'b1;
        s.cfg_val = value;
        s.row     = '0;
        pending.insert(pending.size(), s);
    endfunction

    function automatic void queue_row(int idx, bit [63:0] bits, bit last);
        stim_t s;
        s.is_cfg            = 1'b0;
        s.cfg_val           = '0;
        s.row.row_index     = NODE_W'(idx);
        s.row.row_bits      = bits;
        s.row.last_row      = last;
        pending.insert(pending.size(), s);
        rows_sent++;
    endfunction

    // One well-formed graph: every row below n is sent (so no unwritten row is
    // ever read), in shuffled order, with some noise rows at or above n mixed in.
    // Bits at or above n are random; the block must ignore them.
    function automatic void queue_graph(int n, int kind);
        bit [63:0] rows_l [64];
        int        perm [64];
        int        p, t, j, tail_noise;
        p = $urandom_range(60, 5);
        for (int i = 0; i < n; i++)
        begin
            rows_l[i] = {$urandom, $urandom};
            for (j = 0; j < n; j++)
            begin
                case (kind)
                    G_DAG:    rows_l[i][j] = (j > i) && ($urandom_range(99) < p);
                    G_RANDOM: rows_l[i][j] = ($urandom_range(99) < p);
                    G_EMPTY:  rows_l[i][j] = 1'b0;
                    G_FULL:   rows_l[i][j] = 1'b1;
                    G_SELF:   rows_l[i][j] = (j == i) && (i == n - 1);
                    default:  rows_l[i][j] = (j == (i + 1) % n);
                endcase
            end
            perm[i] = i;
        end
        for (int i = n - 1; i > 0; i--)
        begin
            j       = $urandom_range(i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        tail_noise = (n < 64) && ($urandom_range(4) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (n < 64 && $urandom_range(5) == 0)
                queue_row($urandom_range(63, n), {$urandom, $urandom}, 1'b0);
            queue_row(perm[i], rows_l[perm[i]], (i == n - 1) && !tail_noise);
        end
        // a last row may also carry a node outside the active set
        if (tail_noise)
            queue_row($urandom_range(63, n), {$urandom, $urandom}, 1'b1);
    endfunction

    initial
    begin
        int cfg_v, n;
        errors       = 0;
        rows_sent    = 0;
        node_count_q = 7'd64;
        // Directed part: smallest count (0 acts as 1), self-loop, simple
        // shapes, full graph, ring, a last row outside the active nodes,
        // and one full-size graph with a count above the maximum.
        queue_cfg(7'd0);
        queue_graph(1, G_EMPTY);
        queue_graph(1, G_FULL);
        queue_cfg(7'd1);
        queue_graph(1, G_SELF);
        queue_cfg(7'd4);
        queue_graph(4, G_DAG);
        queue_graph(4, G_RING);
        queue_graph(4, G_SELF);
        queue_graph(4, G_FULL);
        queue_row(63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        queue_row(10, 64'h0, 1'b1);
        queue_cfg(7'd127);
        queue_graph(64, G_RANDOM);
        // Random part: small graphs.
        while (rows_sent < 105)
        begin
            cfg_v = $urandom_range(9, 2);
            queue_cfg(7'(cfg_v));
            n = cfg_v;
            repeat ($urandom_range(2, 1))
                queue_graph(n, ($urandom_range(9) < 6) ? G_RANDOM
                                                       : $urandom_range(G_RING, G_DAG));
        end

        @(posedge rst_n);
        while (pending.size() != 0 || in_ch.valid || cfg_ch.valid
               || results_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("scc_or_topological_sort_tb: done, clean");
        else
            $display("scc_or_topological_sort_tb: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("scc_or_topological_sort_tb: done, errors");
        $finish;
    end

    // Driver: everything changes on the falling edge.
    always @(negedge clk)
    begin
        bit next_in_v;
        bit next_cfg_v;
        if (rst_n)
        begin
            next_in_v  = in_ch.valid && !in_fire;
            next_cfg_v = cfg_ch.valid && !cfg_fire;
            if (!next_in_v && !next_cfg_v)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() != 0)
                begin
                    if (pending[0].is_cfg)
                    begin
                        // register writes only once the block is idle
                        if (results_due.size() == 0 && quiet >= QUIET_CYCLES)
                        begin
                            cfg_ch.data <= pending[0].cfg_val;
                            next_cfg_v = 1'b1;
                            void'(pending.pop_front());
                        end
                    end
                    else
                    begin
                        in_ch.payload <= pending[0].row;
                        next_in_v = 1'b1;
                        void'(pending.pop_front());
                        send_gap = pick_gap();
                    end
                end
            end
            in_ch.valid  <= next_in_v;
            cfg_ch.valid <= next_cfg_v;

            // output backpressure
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Monitor: sample transactions on the rising edge, predict and check.
    always @(posedge clk)
    begin
        scc_out_t exp_r;
        scc_out_t got;
        in_fire  <= in_ch.valid && in_ch.ready;
        cfg_fire <= cfg_ch.valid && cfg_ch.ready;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                node_count_q = cfg_ch.data;
            if (in_ch.valid && in_ch.ready)
            begin
                graph_rows[in_ch.payload.row_index] = in_ch.payload.row_bits;
                if (in_ch.payload.last_row)
                    predict_run();
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: node_id %0d", got.node_id);
                    errors++;
                end
                else
                begin
                    exp_r = results_due.pop_front();
                    if (got.graph_cyclic !== exp_r.graph_cyclic)
                    begin
                        $error("graph_cyclic: expected %0d, got %0d",
                               exp_r.graph_cyclic, got.graph_cyclic);
                        errors++;
                    end
                    if (got.node_id !== exp_r.node_id)
                    begin
                        $error("node_id: expected %0d, got %0d",
                               exp_r.node_id, got.node_id);
                        errors++;
                    end
                    if (got.component_index !== exp_r.component_index)
                    begin
                        $error("component_index: expected %0d, got %0d",
                               exp_r.component_index, got.component_index);
                        errors++;
                    end
                    if (got.component_end !== exp_r.component_end)
                    begin
                        $error("component_end: expected %0d, got %0d",
                               exp_r.component_end, got.component_end);
                        errors++;
                    end
                    if (got.run_end !== exp_r.run_end)
                    begin
                        $error("run_end: expected %0d, got %0d",
                               exp_r.run_end, got.run_end);
                        errors++;
                    end
                end
            end
            if (results_due.size() != 0 || in_ch.valid)
                quiet <= 0;
            else
                quiet <= quiet + 1;
        end
        else
            quiet <= 0;
    end

endmodule
